### rtl/les_pkg.sv
// Shared types, register indexes and logit table arithmetic for the edge sampler.
`default_nettype none
package les_pkg;

    localparam int NUM_FEATS     = 5;
    localparam int IDX_MAX_BITS  = 14;
    localparam int PROD_BITS     = 40;
    localparam int SUM_BITS      = 44;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_BITS    = 2;
    localparam int Q_CNT_BITS    = 3;
    localparam int DEF_VERTEX_BITS      = 16;
    localparam int DEF_MAX_COVARIATES   = 5;
    localparam int DEF_LOGIT_TABLE_BITS = 10;
    localparam logic [63:0] LN2_Q32 = 64'd2977044472;

    localparam logic [2:0] CFG_DIRECTED   = 3'd0;
    localparam logic [2:0] CFG_COUNT      = 3'd1;
    localparam logic [2:0] CFG_BIAS       = 3'd2;
    localparam logic [2:0] CFG_COEF_ONE   = 3'd3;
    localparam logic [2:0] CFG_COEF_TWO   = 3'd4;
    localparam logic [2:0] CFG_COEF_THREE = 3'd5;
    localparam logic [2:0] CFG_COEF_FOUR  = 3'd6;
    localparam logic [2:0] CFG_COEF_FIVE  = 3'd7;

    typedef logic signed [23:0]          t_coef;
    typedef logic signed [15:0]          t_feat;
    typedef logic signed [PROD_BITS-1:0] t_prod;

    typedef struct packed {
        logic                          eligible;
        logic [15:0]                   row;
        logic [15:0]                   col;
        logic [IDX_MAX_BITS-1:0]       idx;
        logic [NUM_FEATS*PROD_BITS-1:0] prods;
    } t_item;

    function automatic logic signed [63:0] log2_q24(input logic [31:0] n);
        logic [5:0]  e;
        logic [63:0] m;
        logic [23:0] frac;
        e    = '0;
        frac = '0;
        for (int i = 0; i < 29; i++) begin
            if ((n >> (e + 6'd1)) != 32'd0) begin
                e = e + 6'd1;
            end
        end
        m = {32'd0, n} << (6'd30 - e);
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            if (m >= 64'h0000_0000_8000_0000) begin
                frac = {frac[22:0], 1'b1};
                m    = m >> 1;
            end else begin
                frac = {frac[22:0], 1'b0};
            end
        end
        if (n == 32'd0) begin
            return '0;
        end
        return $signed({34'd0, e, frac});
    endfunction

    function automatic logic signed [31:0] logit_entry(input int unsigned k,
                                                       input int unsigned bits);
        logic [31:0]        a;
        logic [31:0]        b;
        logic signed [63:0] d;
        logic [63:0]        mag;
        logic [63:0]        r;
        a   = 32'(2 * k + 1);
        b   = (32'd1 << (bits + 1)) - a;
        d   = log2_q24(a) - log2_q24(b);
        mag = d[63] ? 64'(-d) : 64'(d);
        r   = (mag * LN2_Q32 + 64'h0000_0000_8000_0000) >> 32;
        return d[63] ? -$signed(r[31:0]) : $signed(r[31:0]);
    endfunction

endpackage
`default_nettype wire

### rtl/les_front.sv
// Front stage: eligibility check, index extraction and covariate products.
`default_nettype none
module les_front import les_pkg::*; #(
    parameter int VERTEX_BITS      = DEF_VERTEX_BITS,
    parameter int MAX_COVARIATES   = DEF_MAX_COVARIATES,
    parameter int LOGIT_TABLE_BITS = DEF_LOGIT_TABLE_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [175:0] i_data,
    input  wire logic        i_directed,
    input  wire logic [2:0]  i_count,
    input  wire t_coef       i_coef [NUM_FEATS],
    output logic             o_valid,
    input  wire logic        i_q_ready,
    output t_item            o_item
);
    localparam int CMP_BITS = (VERTEX_BITS < 16) ? VERTEX_BITS : 16;
    localparam logic [2:0] MAX_CNT = 3'(MAX_COVARIATES);

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic [2:0]  w_cnt;
    logic [CMP_BITS-1:0] w_row;
    logic [CMP_BITS-1:0] w_col;
    t_feat       w_feat [NUM_FEATS];
    t_prod       w_prod [NUM_FEATS];

    assign o_ready = !r_valid || i_q_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign w_row   = i_data[CMP_BITS-1:0];
    assign w_col   = i_data[16 +: CMP_BITS];
    assign w_cnt   = (i_count > MAX_CNT) ? MAX_CNT : i_count;

    always_comb begin
        for (int p = 0; p < NUM_FEATS; p++) begin
            w_feat[p] = $signed(i_data[96 + 16*p +: 16]);
            if (p < MAX_COVARIATES && 3'(p) < w_cnt) begin
                w_prod[p] = PROD_BITS'(i_coef[p]) * PROD_BITS'(w_feat[p]);
            end else begin
                w_prod[p] = '0;
            end
            n_item.prods[PROD_BITS*p +: PROD_BITS] = w_prod[p];
        end
        n_item.eligible = (i_data[47:32] != i_data[63:48]) &&
                          (i_directed ? (w_row != w_col) : (w_row < w_col));
        n_item.row = i_data[15:0];
        n_item.col = i_data[31:16];
        n_item.idx = IDX_MAX_BITS'(i_data[95 -: LOGIT_TABLE_BITS]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end
endmodule
`default_nettype wire

### rtl/les_queue.sv
// Small first-in first-out queue between the front and back stages.
`default_nettype none
module les_queue import les_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_ready,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);
    t_item                 r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr;
    logic [Q_PTR_BITS-1:0] r_rd;
    logic [Q_CNT_BITS-1:0] r_cnt;
    logic                  w_push;
    logic                  w_pop;

    assign o_ready = (r_cnt != Q_CNT_BITS'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + Q_CNT_BITS'(w_push) - Q_CNT_BITS'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end
endmodule
`default_nettype wire

### rtl/les_back.sv
// Back stages: logit table lookup, predictor sum, compare and output register.
`default_nettype none
module les_back import les_pkg::*; #(
    parameter int LOGIT_TABLE_BITS = DEF_LOGIT_TABLE_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_item       i_item,
    output logic             o_pop,
    input  wire t_coef       i_bias,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [39:0]      o_data
);
    localparam int TABLE_SIZE = 1 << LOGIT_TABLE_BITS;
    typedef logic signed [31:0] t_rom [TABLE_SIZE];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            rom[k] = logit_entry(k, LOGIT_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom LOGIT_ROM = build_rom();

    logic                      w_en;
    t_prod                     w_p [NUM_FEATS];
    logic                      r_v1, r_v2, r_v3;
    logic                      r_el1, r_el2;
    logic [15:0]               r_row1, r_col1, r_row2, r_col2;
    logic signed [SUM_BITS-1:0] r_s0, r_s1, r_s2, r_u;
    logic signed [31:0]        r_logit1, r_logit2;
    logic                      r_edge, r_el3;
    logic [15:0]               r_row3, r_col3;

    assign w_en    = !r_v3 || i_ready;
    assign o_pop   = w_en;
    assign o_valid = r_v3;
    assign o_data  = {6'd0, r_col3, r_row3, r_el3, r_edge};

    always_comb begin
        for (int p = 0; p < NUM_FEATS; p++) begin
            w_p[p] = $signed(i_item.prods[PROD_BITS*p +: PROD_BITS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (w_en) begin
            r_el1    <= i_item.eligible;
            r_row1   <= i_item.row;
            r_col1   <= i_item.col;
            r_logit1 <= LOGIT_ROM[i_item.idx[LOGIT_TABLE_BITS-1:0]];
            r_s0     <= SUM_BITS'($signed({i_bias, 8'd0})) + SUM_BITS'(w_p[0]);
            r_s1     <= SUM_BITS'(w_p[1]) + SUM_BITS'(w_p[2]);
            r_s2     <= SUM_BITS'(w_p[3]) + SUM_BITS'(w_p[4]);
            r_el2    <= r_el1;
            r_row2   <= r_row1;
            r_col2   <= r_col1;
            r_logit2 <= r_logit1;
            r_u      <= r_s0 + r_s1 + r_s2;
            r_el3    <= r_el2;
            r_row3   <= r_row2;
            r_col3   <= r_col2;
            r_edge   <= r_el2 && (r_u > SUM_BITS'(r_logit2));
        end
    end
endmodule
`default_nettype wire

### rtl/logistic_edge_sampler_core.sv
// Top level of the logistic edge sampler: configuration registers and stage wiring.
// Takes one vertex pair per clock while s_axis_tready is high and returns one result per
// pair, in order. A pair passes the front register, the four-entry queue and then the
// three back stages (table read and partial sums, final sum, compare), the last of which
// is the output register. The back pipeline stalls as a whole while the output
// transaction waits; the queue absorbs the front's work meanwhile.
`default_nettype none
module logistic_edge_sampler_core import les_pkg::*; #(
    parameter int VERTEX_BITS      = DEF_VERTEX_BITS,
    parameter int MAX_COVARIATES   = DEF_MAX_COVARIATES,
    parameter int LOGIT_TABLE_BITS = DEF_LOGIT_TABLE_BITS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // row_vertex, col_vertex, row_block, col_block, uniform_sample, feat_one..feat_five
    input  wire logic [175:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // edge_present, pair_eligible, out_row, out_col, zero fill
    output logic [39:0]       m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [23:0]  i_cfg_data
);
    logic        r_directed;
    logic [2:0]  r_count;
    t_coef       r_bias;
    t_coef       r_coef [NUM_FEATS];
    logic        w_f_valid, w_q_ready, w_q_valid, w_pop;
    t_item       w_f_item, w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_directed <= 1'b0;
            r_count    <= '0;
            r_bias     <= '0;
            for (int p = 0; p < NUM_FEATS; p++) r_coef[p] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIRECTED:   r_directed <= i_cfg_data[0];
                CFG_COUNT:      r_count    <= i_cfg_data[2:0];
                CFG_BIAS:       r_bias     <= $signed(i_cfg_data);
                CFG_COEF_ONE:   r_coef[0]  <= $signed(i_cfg_data);
                CFG_COEF_TWO:   r_coef[1]  <= $signed(i_cfg_data);
                CFG_COEF_THREE: r_coef[2]  <= $signed(i_cfg_data);
                CFG_COEF_FOUR:  r_coef[3]  <= $signed(i_cfg_data);
                CFG_COEF_FIVE:  r_coef[4]  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    les_front #(
        .VERTEX_BITS(VERTEX_BITS),
        .MAX_COVARIATES(MAX_COVARIATES),
        .LOGIT_TABLE_BITS(LOGIT_TABLE_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .i_directed(r_directed), .i_count(r_count), .i_coef(r_coef),
        .o_valid(w_f_valid), .i_q_ready(w_q_ready), .o_item(w_f_item)
    );

    les_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_f_valid), .i_item(w_f_item), .o_ready(w_q_ready),
        .i_pop(w_pop), .o_valid(w_q_valid), .o_item(w_q_item)
    );

    les_back #(
        .LOGIT_TABLE_BITS(LOGIT_TABLE_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .i_item(w_q_item), .o_pop(w_pop), .i_bias(r_bias),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );

    a_edge_needs_eligible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[0] || m_axis_tdata[1]))
        else $error("edge reported for an ineligible pair");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (w_f_valid && !w_q_ready))
        else $error("input stalled while the queue had room");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:34] == 6'd0))
        else $error("output padding not zero");
endmodule
`default_nettype wire

### test/tb_logistic_edge_sampler_core.sv
// Self-checking testbench for the logistic edge sampler core: directed and random pairs.
module tb_logistic_edge_sampler_core;
    import les_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [15:0] col;
        logic [15:0] row;
        logic        pair_eligible;
        logic        edge_present;
    } t_sample_result;

    typedef struct {
        logic [15:0]  row_v;
        logic [15:0]  col_v;
        logic [15:0]  row_b;
        logic [15:0]  col_b;
        logic [31:0]  x;
        logic [15:0]  feat [NUM_FEATS];
        logic         known;
        logic         edge_bit;
        logic         elig_bit;
    } t_pair_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // row_vertex, col_vertex, row_block, col_block, uniform_sample, feat_one..feat_five
    logic [175:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // edge_present, pair_eligible, out_row, out_col, zero fill
    logic [39:0]  m_axis_tdata;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [23:0]  i_cfg_data;

    logistic_edge_sampler_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    logic signed [31:0] logit_lut [1024];
    logic               mode_directed;
    logic [2:0]         term_count;
    logic signed [23:0] weight [NUM_FEATS+1];

    t_sample_result expected_edges [$];
    int  error_count;
    int  idle_cycles;
    bit  calm_phase;
    bit  busy_send;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] log2_fixed(input logic [31:0] n);
        int unsigned e;
        logic [63:0] m;
        logic [23:0] frac;
        e = 0;
        frac = '0;
        if (n == 0) return 0;
        while (e < 29 && (n >> (e + 1)) != 0) e++;
        m = 64'(n) << (30 - e);
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (64'(e) << 24) + 64'(frac);
    endfunction

    task automatic build_logit_lut();
        logic [31:0] a, b;
        logic signed [63:0] d;
        logic [63:0] mag, r;
        for (int k = 0; k < 1024; k++) begin
            a = 32'(2 * k + 1);
            b = 32'd2048 - a;
            d = log2_fixed(a) - log2_fixed(b);
            mag = d < 0 ? -d : d;
            r = (mag * 64'd2977044472 + 64'h8000_0000) >> 32;
            logit_lut[k] = d < 0 ? -$signed(r[31:0]) : $signed(r[31:0]);
        end
    endtask

    function automatic t_sample_result predict_edge(t_pair_row p);
        t_sample_result res;
        logic signed [63:0] u;
        int cnt;
        cnt = term_count > 5 ? 5 : term_count;
        res.pair_eligible = (p.row_b != p.col_b) &&
            (mode_directed ? (p.row_v != p.col_v) : (p.row_v < p.col_v));
        u = 64'(weight[0]) * 256;
        for (int i = 0; i < cnt; i++) u += 64'(weight[i+1]) * 64'($signed(p.feat[i]));
        res.edge_present = res.pair_eligible && (u > 64'(logit_lut[p.x[31:22]]));
        res.row = p.row_v;
        res.col = p.col_v;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        error_count++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_DIRECTED: mode_directed = val[0];
            CFG_COUNT:    term_count = val[2:0];
            default:      weight[idx - CFG_BIAS] = val;
        endcase
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while (expected_edges.size() != 0 && guard < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_pair(t_pair_row p);
        if (!calm_phase && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_axis_tdata  <= {p.feat[4], p.feat[3], p.feat[2], p.feat[1], p.feat[0],
                          p.x, p.col_b, p.row_b, p.col_v, p.row_v};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_edges.push_back(predict_edge(p));
        if (p.known && (expected_edges[$].edge_present != p.edge_bit ||
                        expected_edges[$].pair_eligible != p.elig_bit))
            report_mismatch("table row", {p.edge_bit, p.elig_bit},
                {expected_edges[$].edge_present, expected_edges[$].pair_eligible});
        @(negedge i_clk);
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic t_pair_row random_pair();
        t_pair_row p;
        logic [15:0] r, c;
        r = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 15));
        c = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 15));
        p.row_v = r;
        p.col_v = c;
        p.row_b = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2));
        p.col_b = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2));
        p.x = $urandom;
        for (int i = 0; i < NUM_FEATS; i++) p.feat[i] = 16'($urandom);
        p.known = 1'b0;
        p.edge_bit = 1'b0;
        p.elig_bit = 1'b0;
        return p;
    endfunction

    function automatic t_pair_row table_pair(input logic [15:0] r, input logic [15:0] c,
            input logic [15:0] rb, input logic [15:0] cb, input logic [31:0] x,
            input logic [15:0] f, input logic known, input logic e, input logic el);
        t_pair_row p;
        p.row_v = r; p.col_v = c; p.row_b = rb; p.col_b = cb; p.x = x;
        for (int i = 0; i < NUM_FEATS; i++) p.feat[i] = f;
        p.known = known; p.edge_bit = e; p.elig_bit = el;
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_sample_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[33:0];
            if (expected_edges.size() == 0) begin
                report_mismatch("unexpected result", got[31:0], 0);
            end else begin
                want = expected_edges.pop_front();
                if (got.edge_present != want.edge_present)
                    report_mismatch("edge_present", got.edge_present, want.edge_present);
                if (got.pair_eligible != want.pair_eligible)
                    report_mismatch("pair_eligible", got.pair_eligible, want.pair_eligible);
                if (got.row != want.row) report_mismatch("out_row", got.row, want.row);
                if (got.col != want.col) report_mismatch("out_col", got.col, want.col);
            end
        end
    end

    always @(negedge i_clk) begin
        if (calm_phase || idle_cycles > 0) begin
            if (idle_cycles > 0) idle_cycles <= idle_cycles - 1;
            m_axis_tready <= calm_phase ? 1'b1 : (idle_cycles <= 1);
        end else if ($urandom_range(0, 7) == 0) begin
            idle_cycles   <= $urandom_range(1, 12);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (!busy_send && expected_edges.size() == 0))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        t_pair_row dir_rows [$];
        logic [23:0] setting;
        busy_send     = 1'b0;
        calm_phase    = 1'b0;
        error_count   = 0;
        idle_cycles   = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_DIRECTED;
        i_cfg_data    = '0;
        mode_directed = 1'b0;
        term_count    = '0;
        for (int i = 0; i <= NUM_FEATS; i++) weight[i] = '0;
        build_logit_lut();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset config: u = 0, edges need logit(x) < 0
        dir_rows.push_back(table_pair(0, 1, 0, 1, 32'h0000_0001, 16'h7FFF, 1, 1, 1));
        dir_rows.push_back(table_pair(0, 1, 0, 1, 32'hFFFF_FFFF, 16'h8000, 1, 0, 1));
        dir_rows.push_back(table_pair(0, 1, 0, 1, 32'h0000_0000, 16'h0000, 1, 1, 1));
        dir_rows.push_back(table_pair(1, 0, 0, 1, 32'h0000_0001, 16'h0000, 1, 0, 0));
        dir_rows.push_back(table_pair(5, 5, 0, 1, 32'h0000_0001, 16'h0000, 1, 0, 0));
        dir_rows.push_back(table_pair(0, 1, 7, 7, 32'h0000_0001, 16'h0000, 1, 0, 0));
        dir_rows.push_back(table_pair(16'hFFFE, 16'hFFFF, 16'hFFFF, 0, 32'h1,
                                      16'h0, 1, 1, 1));
        busy_send = 1'b1;
        foreach (dir_rows[i]) send_pair(dir_rows[i]);
        end_burst();
        busy_send = 1'b0;
        wait_idle();

        write_reg(CFG_DIRECTED, 24'd1);
        write_reg(CFG_COUNT, 24'd7);
        write_reg(CFG_BIAS, 24'h7FFFFF);
        write_reg(CFG_COEF_ONE, 24'h800000);
        write_reg(CFG_COEF_TWO, 24'h7FFFFF);
        write_reg(CFG_COEF_THREE, 24'h800000);
        write_reg(CFG_COEF_FOUR, 24'h000001);
        write_reg(CFG_COEF_FIVE, 24'hFFFFFF);
        dir_rows.delete();
        dir_rows.push_back(table_pair(5, 5, 0, 1, 32'h8000_0000, 16'h7FFF, 0, 0, 0));
        dir_rows.push_back(table_pair(9, 3, 0, 1, 32'h8000_0000, 16'h8000, 0, 0, 0));
        dir_rows.push_back(table_pair(3, 9, 2, 1, 32'hFFFF_FFFF, 16'h7FFF, 0, 0, 0));
        dir_rows.push_back(table_pair(3, 9, 2, 1, 32'h0000_0000, 16'h8000, 0, 0, 0));
        busy_send = 1'b1;
        foreach (dir_rows[i]) send_pair(dir_rows[i]);
        end_burst();
        busy_send = 1'b0;
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            write_reg(CFG_DIRECTED, 24'($urandom_range(0, 1)));
            write_reg(CFG_COUNT, 24'(phase == 0 ? 0 : $urandom_range(0, 7)));
            for (int w = 0; w <= NUM_FEATS; w++) begin
                case ($urandom_range(0, 3))
                    0: setting = 24'h7FFFFF;
                    1: setting = 24'h800000;
                    default: setting = 24'($signed(9'($urandom_range(0, 511)))) <<< 8;
                endcase
                if (phase == 7) setting = 24'($urandom);
                write_reg(3'(CFG_BIAS + w), setting);
            end
            calm_phase = (phase == 7);
            busy_send = 1'b1;
            for (int n = 0; n < 160; n++) send_pair(random_pair());
            end_burst();
            busy_send = 1'b0;
            wait_idle();
        end

        if (expected_edges.size() != 0) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
